[rtl/dgt_pkg.sv]
// Shared constants, types and helpers of the depth grid triangulator.
// Depends on nothing; every other file of the block but dgt_ram imports it.
package dgt_pkg;

    // Grid and sample limits.
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_SLICES  = 1024;
    localparam int DEPTH_BITS  = 16;

    // Derived widths.
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ACT_W   = COL_W + 1;
    localparam int SLICE_W = $clog2(MAX_SLICES);
    localparam int PROD_W  = SLICE_W + ACT_W;
    localparam int IDX_W   = PROD_W + 1;
    localparam int SQ_W    = 2 * DEPTH_BITS;

    // Register and result field widths.
    localparam int CFG_COLS_W = 11;
    localparam int EDGE_W     = 33;
    localparam int VERT_W     = 20;
    localparam int FACE_W     = 21;
    localparam int SUM_W      = ((SQ_W + 1 > EDGE_W) ? SQ_W + 1 : EDGE_W) + 1;

    localparam logic [FACE_W-1:0] FACE_MAX = {FACE_W{1'b1}};

    // Register file layout and reset values.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_COLUMNS  = 1'b0;
    localparam logic REG_MAX_EDGE = 1'b1;
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(1024);
    localparam logic [EDGE_W-1:0]     EDGE_RESET = EDGE_W'(2250000);

    // One grid cell after the square stage, handed to the emitter.
    typedef struct packed {
        logic              cell_ok;
        logic              frame;
        logic [PROD_W-1:0] prod;
        logic [COL_W-1:0]  col;
        logic [ACT_W-1:0]  cols;
        logic [SQ_W-1:0]   sq_ab;
        logic [SQ_W-1:0]   sq_ac;
        logic [SQ_W-1:0]   sq_bc;
        logic [SQ_W-1:0]   sq_bd;
        logic [SQ_W-1:0]   sq_cd;
    } cell_t;

    // Absolute difference of two depth samples.
    function automatic logic [DEPTH_BITS-1:0] abs_diff(
        input logic [DEPTH_BITS-1:0] p,
        input logic [DEPTH_BITS-1:0] q
    );
        abs_diff = (p > q) ? (p - q) : (q - p);
    endfunction

endpackage

[rtl/dgt_in_if.sv]
// Sample channel of the depth grid triangulator: valid, ready and one sample.
// Depends on dgt_pkg.
interface dgt_in_if;
    import dgt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth;
    logic                  frame_start;

    modport source (output valid, output depth, output frame_start, input ready);
    modport sink (input valid, input depth, input frame_start, output ready);
endinterface

[rtl/dgt_out_if.sv]
// Triangle channel of the depth grid triangulator: valid, ready and one face.
// Depends on dgt_pkg.
interface dgt_out_if;
    import dgt_pkg::*;

    logic              valid;
    logic              ready;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [VERT_W-1:0] vertex_c;
    logic [FACE_W-1:0] face_number;
    logic              last;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    output face_number, output last, input ready);
    modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input face_number, input last, output ready);
endinterface

[rtl/dgt_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read.
// Stand-alone; used for the previous-slice line store.
module dgt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/dgt_cfg.sv]
// APB register file: column count and squared edge bound, with clamping.
// Depends on dgt_pkg.
module dgt_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dgt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dgt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dgt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [dgt_pkg::ACT_W-1:0]          cols,
    output logic [dgt_pkg::EDGE_W-1:0]         max_edge
);
    import dgt_pkg::*;

    logic [CFG_COLS_W-1:0] cols_reg;
    logic [EDGE_W-1:0]     max_edge_reg;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= COLS_RESET;
            max_edge_reg <= EDGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_COLUMNS:  cols_reg     <= pwdata[CFG_COLS_W-1:0];
                REG_MAX_EDGE: max_edge_reg <= pwdata[EDGE_W-1:0];
                default:      cols_reg     <= cols_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_sel)
            REG_COLUMNS:  prdata = APB_DATA_W'(cols_reg);
            REG_MAX_EDGE: prdata = APB_DATA_W'(max_edge_reg);
            default:      prdata = '0;
        endcase
    end

    // Column count in use is held between two and the line store size.
    always_comb
    begin
        if (int'(cols_reg) < 2)
        begin
            cols = ACT_W'(2);
        end
        else if (int'(cols_reg) > MAX_COLUMNS)
        begin
            cols = ACT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = ACT_W'(cols_reg);
        end
    end

    assign max_edge = max_edge_reg;
endmodule

[rtl/dgt_front.sv]
// Sample intake: grid position, line store access and the edge square stage.
// Depends on dgt_pkg, dgt_in_if and dgt_ram.
module dgt_front (
    input  logic                      clk,
    input  logic                      rst_n,
    dgt_in_if.sink                    in,
    input  logic [dgt_pkg::ACT_W-1:0] cols,
    output logic                      cell_valid,
    output dgt_pkg::cell_t            cell_data,
    input  logic                      cell_take
);
    import dgt_pkg::*;

    // Grid position and running neighbors.
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [SLICE_W-1:0]    slice_reg;
    logic [SLICE_W-1:0]    slice_next;
    logic [DEPTH_BITS-1:0] prev_sample_reg;
    logic [DEPTH_BITS-1:0] upper_left_reg;

    // Square stage registers.
    logic                  s1_valid_reg;
    logic                  s1_frame_reg;
    logic                  s1_ok_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [SLICE_W-1:0]    s1_slice_reg;
    logic [ACT_W-1:0]      s1_cols_reg;
    logic [DEPTH_BITS-1:0] s1_c_reg;
    logic [DEPTH_BITS-1:0] s1_d_reg;

    logic                  accept;
    logic                  s1_move;
    logic [COL_W-1:0]      col_eff;
    logic [SLICE_W-1:0]    slice_eff;
    logic [ACT_W-1:0]      col_inc;
    logic [SLICE_W:0]      slice_inc;
    logic                  cell_ok;
    logic [DEPTH_BITS-1:0] old_entry;
    logic [SLICE_W-1:0]    slice_m1;

    assign s1_move    = s1_valid_reg && cell_take;
    assign in.ready   = !s1_valid_reg || cell_take;
    assign accept     = in.valid && in.ready;
    assign cell_valid = s1_valid_reg;

    // A new map starts at the top left corner.
    assign col_eff   = in.frame_start ? '0 : col_reg;
    assign slice_eff = in.frame_start ? '0 : slice_reg;
    assign col_inc   = ACT_W'(col_eff) + ACT_W'(1);
    assign slice_inc = (SLICE_W+1)'(slice_eff) + (SLICE_W+1)'(1);
    assign cell_ok   = (slice_eff != '0) && (col_eff != '0) && (ACT_W'(col_eff) < cols);

    // Raster walk: wrap to the next slice at the end of a row.
    always_comb
    begin
        if (col_inc >= cols)
        begin
            col_next   = '0;
            slice_next = (slice_inc >= (SLICE_W+1)'(MAX_SLICES)) ? '0
                                                                 : slice_inc[SLICE_W-1:0];
        end
        else
        begin
            col_next   = col_inc[COL_W-1:0];
            slice_next = slice_eff;
        end
    end

    // Line store: the old entry is read while the new sample replaces it.
    dgt_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_eff),
        .wdata (in.depth),
        .re    (accept),
        .raddr (col_eff),
        .rdata (old_entry)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            slice_reg       <= '0;
            prev_sample_reg <= '0;
            upper_left_reg  <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg         <= col_next;
                slice_reg       <= slice_next;
                prev_sample_reg <= in.depth;
            end
            if (s1_move)
            begin
                upper_left_reg <= old_entry;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Sample payload held for the square stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg <= in.frame_start;
            s1_ok_reg    <= cell_ok;
            s1_col_reg   <= col_eff;
            s1_slice_reg <= slice_eff;
            s1_cols_reg  <= cols;
            s1_c_reg     <= prev_sample_reg;
            s1_d_reg     <= in.depth;
        end
    end

    // Corners: A upper left, B from the line store, C previous sample, D current.
    assign slice_m1 = s1_slice_reg - SLICE_W'(1);

    always_comb
    begin
        cell_data.cell_ok = s1_ok_reg;
        cell_data.frame   = s1_frame_reg;
        cell_data.prod    = PROD_W'(slice_m1) * PROD_W'(s1_cols_reg);
        cell_data.col     = s1_col_reg;
        cell_data.cols    = s1_cols_reg;
        cell_data.sq_ab   = SQ_W'(abs_diff(upper_left_reg, old_entry))
                          * SQ_W'(abs_diff(upper_left_reg, old_entry));
        cell_data.sq_ac   = SQ_W'(abs_diff(upper_left_reg, s1_c_reg))
                          * SQ_W'(abs_diff(upper_left_reg, s1_c_reg));
        cell_data.sq_bc   = SQ_W'(abs_diff(old_entry, s1_c_reg))
                          * SQ_W'(abs_diff(old_entry, s1_c_reg));
        cell_data.sq_bd   = SQ_W'(abs_diff(old_entry, s1_d_reg))
                          * SQ_W'(abs_diff(old_entry, s1_d_reg));
        cell_data.sq_cd   = SQ_W'(abs_diff(s1_c_reg, s1_d_reg))
                          * SQ_W'(abs_diff(s1_c_reg, s1_d_reg));
    end
endmodule

[rtl/dgt_emit.sv]
// Edge test, vertex numbering, face counter and the triangle output register.
// Depends on dgt_pkg and dgt_out_if.
module dgt_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dgt_pkg::EDGE_W-1:0] max_edge,
    input  logic                       cell_valid,
    input  dgt_pkg::cell_t             cell_data,
    output logic                       cell_take,
    dgt_out_if.source                  out
);
    import dgt_pkg::*;

    cell_t             s2_reg;
    logic              s2_valid_reg;
    logic              phase_reg;
    logic [FACE_W-1:0] face_reg;

    logic              out_valid_reg;
    logic [VERT_W-1:0] va_reg;
    logic [VERT_W-1:0] vb_reg;
    logic [VERT_W-1:0] vc_reg;
    logic [FACE_W-1:0] face_out_reg;
    logic              last_reg;

    logic              e_ab;
    logic              e_ac;
    logic              e_bc;
    logic              e_bd;
    logic              e_cd;
    logic              t1;
    logic              t2;
    logic              cur1;
    logic              cur2;
    logic              has_tri;
    logic              out_free;
    logic              push;
    logic              last_tri;
    logic              retire;
    logic              load;
    logic [IDX_W-1:0]  ia;
    logic [IDX_W-1:0]  ib;
    logic [IDX_W-1:0]  ic;
    logic [IDX_W-1:0]  id;

    // Squared edge length strictly below the bound.
    function automatic logic edge_below(
        input logic [SQ_W-1:0]   sq,
        input logic [1:0]        planar,
        input logic [EDGE_W-1:0] lim
    );
        edge_below = (SUM_W'(sq) + SUM_W'(planar)) < SUM_W'(lim);
    endfunction

    assign e_ab = edge_below(s2_reg.sq_ab, 2'd1, max_edge);
    assign e_ac = edge_below(s2_reg.sq_ac, 2'd1, max_edge);
    assign e_bc = edge_below(s2_reg.sq_bc, 2'd2, max_edge);
    assign e_bd = edge_below(s2_reg.sq_bd, 2'd1, max_edge);
    assign e_cd = edge_below(s2_reg.sq_cd, 2'd1, max_edge);

    assign t1 = s2_reg.cell_ok && e_ab && e_ac && e_bc;
    assign t2 = s2_reg.cell_ok && e_bc && e_bd && e_cd;

    // Vertex indices of the cell corners.
    assign ia = IDX_W'(s2_reg.prod) + IDX_W'(s2_reg.col) - IDX_W'(1);
    assign ib = ia + IDX_W'(1);
    assign ic = ia + IDX_W'(s2_reg.cols);
    assign id = ic + IDX_W'(1);

    // One triangle per cycle while the output register is free: the first, then the second where both pass.
    assign cur1     = s2_valid_reg && !phase_reg && t1;
    assign cur2     = s2_valid_reg && (phase_reg || !t1) && t2;
    assign has_tri  = cur1 || cur2;
    assign out_free = !out_valid_reg || out.ready;
    assign push     = has_tri && out_free;
    assign last_tri = cur2 || (cur1 && !t2);
    assign retire   = s2_valid_reg && (!has_tri || (push && last_tri));
    assign cell_take = !s2_valid_reg || retire;
    assign load     = cell_valid && cell_take;

    // Emit stage and face counter control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            face_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (load || retire)
            begin
                phase_reg <= 1'b0;
            end
            else if (push && cur1)
            begin
                phase_reg <= 1'b1;
            end

            // A new map restarts the numbering; otherwise count up and hold at full.
            if (load && cell_data.frame)
            begin
                face_reg <= '0;
            end
            else if (push && (face_reg != FACE_MAX))
            begin
                face_reg <= face_reg + FACE_W'(1);
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Cell and triangle payloads.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg <= cell_data;
        end
        if (push)
        begin
            va_reg       <= cur1 ? ia[VERT_W-1:0] : ib[VERT_W-1:0];
            vb_reg       <= cur1 ? ib[VERT_W-1:0] : ic[VERT_W-1:0];
            vc_reg       <= cur1 ? ic[VERT_W-1:0] : id[VERT_W-1:0];
            face_out_reg <= face_reg;
            last_reg     <= last_tri;
        end
    end

    assign out.valid       = out_valid_reg;
    assign out.vertex_a    = va_reg;
    assign out.vertex_b    = vb_reg;
    assign out.vertex_c    = vc_reg;
    assign out.face_number = face_out_reg;
    assign out.last        = last_reg;

`ifndef SYNTH
    // After the first of two triangles the stage waits on the second.
    a_phase_set: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cur1 && t2) |=> phase_reg)
        else $error("second triangle not pending after first transfer");

    // The second-triangle phase exists only for a held cell whose second triangle passes.
    a_phase_cell: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (s2_valid_reg && t2))
        else $error("second-triangle phase without a passing cell");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out.ready) |-> !push)
        else $error("output register overwritten while stalled");

    // Each emitted face advances the counter by one unless full or restarted.
    a_face_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !(load && cell_data.frame) && (face_reg != FACE_MAX))
        |=> (face_reg == $past(face_reg) + FACE_W'(1)))
        else $error("face counter did not advance");
`endif
endmodule

[rtl/depth_grid_triangulator.sv]
// Top level of the depth grid triangulator: register file, intake and emitter.
// Depends on dgt_pkg, dgt_in_if, dgt_out_if, dgt_cfg, dgt_front and dgt_emit.
//
// Usage:
// Depth samples enter in raster order on the "in" channel, one transfer per
// sample; frame_start on a sample restarts the grid position and face count.
// Each sample completing a grid cell gives zero, one or two triangles on the
// "out" channel, one triangle per transfer, with last set on the final one.
// The APB port sets the row length and the squared edge bound; write it only
// while no sample is in flight.
// A sample passes the square stage and emit stage registers before its triangles reach the output register.
// Throughput: one sample per cycle unless stalled; a sample that yields two
// triangles holds the emit stage for both, as the output carries one face per cycle.
// Stalls back up through the output register, emit stage and square stage;
// in.ready drops when the square and emit stages are both occupied and the
// emit stage cannot release its cell, because the output is stalled or a
// second triangle is still owed.
// Reset clears the position, face counter and pipeline valids and loads the
// register defaults; the line store needs no clearing, as each row is written
// before it is read.
module depth_grid_triangulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dgt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dgt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dgt_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    dgt_in_if.sink                         in,
    dgt_out_if.source                      out
);
    import dgt_pkg::*;

    logic [ACT_W-1:0]  cols;
    logic [EDGE_W-1:0] max_edge;
    logic              cell_valid;
    logic              cell_take;
    cell_t             cell_data;

    dgt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cols     (cols),
        .max_edge (max_edge)
    );

    dgt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .cols       (cols),
        .cell_valid (cell_valid),
        .cell_data  (cell_data),
        .cell_take  (cell_take)
    );

    dgt_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_edge   (max_edge),
        .cell_valid (cell_valid),
        .cell_data  (cell_data),
        .cell_take  (cell_take),
        .out        (out)
    );
endmodule
